// File: design/slc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// set-associative LRU tag store.
// ----------------------------------------------------------------------------
package slc_pkg;

   localparam int ADDR_W             = 32;
   localparam int CFG_W              = 2;
   localparam int WAY_W              = 2;
   localparam int STAMP_W            = 32;
   localparam int BLOCKS_DEFAULT     = 4;
   localparam int ADDR_BITS_DEFAULT  = 32;
   localparam logic [CFG_W-1:0] CFG_RESET = 2'd1;

   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } slc_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } slc_status_type;

endpackage

`default_nettype wire

// File: design/slc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_if
// Valid/ready channels for lookup requests, lookup responses and the
// configuration register.
// ----------------------------------------------------------------------------
interface slc_req_if;
   logic                       valid;
   logic                       ready;
   logic [slc_pkg::ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface slc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [slc_pkg::WAY_W-1:0] way_index;

   modport source (output valid, output hit, output way_index, input ready);
   modport sink   (input valid, input hit, input way_index, output ready);
endinterface

interface slc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [slc_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/slc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer: accepts a request, walks the ways of its set, then commits the
// update and the response.
// ----------------------------------------------------------------------------
module slc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire slc_pkg::slc_status_type status,
   output slc_pkg::slc_cmd_type    cmd
);
   import slc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } slc_state_type;

   slc_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_last) |=> state_ff == ST_WAIT)
      else $error("scan did not end after last way");

   a_wait_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |=> state_ff == ST_FINISH)
      else $error("compare cycle not followed by finish");

endmodule

`default_nettype wire

// File: design/slc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_datapath
// Tag/stamp memories, valid bits, access counter, way search and response
// register.
// ----------------------------------------------------------------------------
module slc_datapath #(
   parameter int BLOCKS    = slc_pkg::BLOCKS_DEFAULT,
   parameter int ADDR_BITS = slc_pkg::ADDR_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire slc_pkg::slc_cmd_type     cmd,
   output slc_pkg::slc_status_type       status,
   input  wire  [slc_pkg::ADDR_W-1:0]    req_address,
   input  wire                           csr_write,
   input  wire  [slc_pkg::CFG_W-1:0]     csr_data,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic                          rsp_hit,
   output logic [slc_pkg::WAY_W-1:0]     rsp_way_index
);
   import slc_pkg::*;

   localparam int TAG_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int SLOT_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_W  = $clog2(BLOCKS + 1);

   function automatic logic [CFG_W-1:0] eff_log2(input logic [CFG_W-1:0] lg);
      logic [CFG_W-1:0] l;
      l = lg;
      for (int k = 0; k < 3; k++) begin
         if (l != '0 && (32'd1 << l) > BLOCKS) begin
            l = l - 1'b1;
         end
      end
      return l;
   endfunction

   logic [TAG_W-1:0]   tag_mem   [BLOCKS];
   logic [STAMP_W-1:0] stamp_mem [BLOCKS];

   logic [CFG_W-1:0]   cfg_lg_ff;
   logic [BLOCKS-1:0]  valid_ff;
   logic [STAMP_W-1:0] counter_ff;

   logic [TAG_W-1:0]   addr_ff;
   logic [SLOT_W-1:0]  base_ff;
   logic [SLOT_W-1:0]  last_idx_ff;
   logic [SLOT_W-1:0]  idx_ff;

   logic               rd_live_ff;
   logic               rd_first_ff;
   logic [SLOT_W-1:0]  rd_slot_ff;
   logic [TAG_W-1:0]   rd_tag_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   logic               hit_found_ff;
   logic [SLOT_W-1:0]  hit_slot_ff;
   logic               inv_found_ff;
   logic [SLOT_W-1:0]  inv_slot_ff;
   logic [STAMP_W-1:0] min_stamp_ff;
   logic [SLOT_W-1:0]  min_slot_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [WAY_W-1:0]   rsp_way_ff;

   logic [CFG_W-1:0]   lg_eff;
   logic [CNT_W-1:0]   ways;
   logic [2:0]         set_sel;
   logic [SLOT_W-1:0]  base_in;
   logic [SLOT_W-1:0]  rd_addr;
   logic               rd_valid;
   logic [SLOT_W-1:0]  sel_slot;

   always_comb begin
      lg_eff  = eff_log2(cfg_lg_ff);
      ways    = CNT_W'(BLOCKS) >> lg_eff;
      set_sel = req_address[2:0] & 3'((4'd1 << lg_eff) - 4'd1);
      base_in = SLOT_W'(set_sel * ways);
      rd_addr = base_ff + idx_ff;
      rd_valid = valid_ff[rd_slot_ff];
      if (hit_found_ff) begin
         sel_slot = hit_slot_ff;
      end else if (inv_found_ff) begin
         sel_slot = inv_slot_ff;
      end else begin
         sel_slot = min_slot_ff;
      end
   end

   assign status = '{scan_last: (idx_ff == last_idx_ff),
                     out_free:  (!rsp_valid_ff || rsp_ready)};

   // configuration, valid bits, counter, search flags, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lg_ff    <= CFG_RESET;
         valid_ff     <= '0;
         counter_ff   <= STAMP_W'(1);
         rd_live_ff   <= 1'b0;
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            cfg_lg_ff <= csr_data;
         end
         rd_live_ff <= cmd.issue;
         if (cmd.start) begin
            hit_found_ff <= 1'b0;
            inv_found_ff <= 1'b0;
         end else if (rd_live_ff) begin
            if (rd_valid && rd_tag_ff == addr_ff) begin
               hit_found_ff <= 1'b1;
            end
            if (!rd_valid) begin
               inv_found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            valid_ff[sel_slot] <= 1'b1;
            counter_ff         <= counter_ff + 1'b1;
            rsp_valid_ff       <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request context, scan pointer, search results, response fields
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff     <= req_address[TAG_W-1:0];
         base_ff     <= base_in;
         last_idx_ff <= SLOT_W'(ways - 1'b1);
         idx_ff      <= '0;
      end else if (cmd.issue) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.issue) begin
         rd_slot_ff  <= rd_addr;
         rd_first_ff <= (idx_ff == '0);
      end
      if (rd_live_ff) begin
         if (rd_valid && rd_tag_ff == addr_ff && !hit_found_ff) begin
            hit_slot_ff <= rd_slot_ff;
         end
         if (!rd_valid && !inv_found_ff) begin
            inv_slot_ff <= rd_slot_ff;
         end
         if (rd_first_ff || rd_stamp_ff < min_stamp_ff) begin
            min_stamp_ff <= rd_stamp_ff;
            min_slot_ff  <= rd_slot_ff;
         end
      end
      if (cmd.commit) begin
         rsp_hit_ff <= hit_found_ff;
         rsp_way_ff <= WAY_W'(sel_slot);
      end
   end

   // tag and stamp memories: one read, one write port
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
      if (cmd.commit) begin
         tag_mem[sel_slot]   <= addr_ff;
         stamp_mem[sel_slot] <= counter_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_way_index = rsp_way_ff;

   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && valid_ff[$past(sel_slot)])
      else $error("committed slot not valid or response missing");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && hit_found_ff) |-> valid_ff[hit_slot_ff])
      else $error("hit reported on an empty slot");

endmodule

`default_nettype wire

// File: design/set_assoc_lru_cache_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request transfer carries one block address; each response transfer
// returns the hit flag and the slot that was hit or filled. The set is the
// address modulo 2^set_count_log2 (lowered until the set count fits BLOCKS),
// each set holding BLOCKS >> log2 consecutive slots. The ways of the set are
// read one per cycle through the single read port of the tag/stamp memory,
// so a request passes through accept, one read per way, a compare step and
// commit; the reset configuration gives 2 sets over 4 slots, i.e. 2 ways.
// A finished response is held in an output register; the next request is
// taken while it waits. Slot contents and stamps survive a configuration
// write, which must only happen while the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup #(
   parameter int BLOCKS    = slc_pkg::BLOCKS_DEFAULT,
   parameter int ADDR_BITS = slc_pkg::ADDR_BITS_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   slc_req_if.sink   req_ch,
   slc_rsp_if.source rsp_ch,
   slc_csr_if.sink   csr_ch
);
   import slc_pkg::*;

   slc_cmd_type    cmd;
   slc_status_type status;
   logic           req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   slc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   slc_datapath #(
      .BLOCKS    (BLOCKS),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_address   (req_ch.address),
      .csr_write     (csr_ch.valid),
      .csr_data      (csr_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_hit       (rsp_ch.hit),
      .rsp_way_index (rsp_ch.way_index)
   );

endmodule

`default_nettype wire
